/* rtl/sample_ring_buffer_burst_read_macros.svh */
// assertion macros for the sample ring buffer
`ifndef SAMPLE_RING_BUFFER_BURST_READ_MACROS_SVH
`define SAMPLE_RING_BUFFER_BURST_READ_MACROS_SVH
`ifndef SYNTH
`define SRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sample ring buffer check failed");
`define SRB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sample ring buffer check failed");
`else
`define SRB_ASSERT(lbl, prop)
`define SRB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/srb_pkg.sv */
// types and codes shared by the sample ring buffer
`default_nettype none
package srb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 7;
  localparam int LEVEL_W  = 10;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [LEN_W-1:0]           burst_len;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;
    logic                       underflow;
    logic [LEVEL_W-1:0]         level;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

endpackage
`default_nettype wire

/* rtl/sample_ring_buffer_burst_read.sv */
// write and clear requests complete when taken; a read holds the request side to its last issue
// a read's first result passes the burst state, read data and output registers
// burst rate is set by the single memory read port: one sample per cycle unless stalled
// a stalled result side pauses the burst without losing samples
// reset (rst, synchronous) zeroes both pointers; the sample memory itself is never cleared
`default_nettype none
`include "sample_ring_buffer_burst_read_macros.svh"
module sample_ring_buffer_burst_read #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire srb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output srb_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > srb_pkg::LEN_W) ? PW : srb_pkg::LEN_W;

  // sample memory: one write port, one registered read port
  logic signed [srb_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic signed [srb_pkg::SAMPLE_W-1:0] rd_data;

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  srb_pkg::state_t state, state_next;

  // burst bookkeeping
  logic [srb_pkg::LEN_W-1:0]   cnt;
  logic                        burst_under;
  logic [srb_pkg::LEVEL_W-1:0] burst_level;

  // read issued and not yet moved out, data sits in rd_data
  logic                        pend;
  logic                        pend_last;
  logic                        pend_under;
  logic [srb_pkg::LEVEL_W-1:0] pend_level;

  logic                        accept;
  logic                        issue;
  logic                        move;
  logic                        rd_en;
  logic                        wr_en;
  logic                        start_read;
  logic [srb_pkg::LEN_W-1:0]   len_sat;
  logic [PW-1:0]               avail;
  logic                        under;

  assign accept = req_valid && req_ready;
  assign move   = pend && (!rsp_valid || rsp_ready);
  assign rd_en  = issue && !burst_under;
  assign wr_en  = accept && (req.func == srb_pkg::FUNC_WRITE);

  // saturate burst length, zero length means no read at all
  assign len_sat = (req.burst_len > srb_pkg::LEN_W'(MAX_BURST)) ?
                   srb_pkg::LEN_W'(MAX_BURST) : req.burst_len;
  assign start_read = accept && (req.func == srb_pkg::FUNC_READ) && (len_sat != '0);

  // fill level, pointer difference modulo depth
  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      avail = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      avail = PW'(DEPTH) - {1'b0, rd_ptr} + {1'b0, wr_ptr};
    end
  end
  assign under = CW'(avail) < CW'(len_sat);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srb_pkg::ST_IDLE: begin
        if (start_read) state_next = srb_pkg::ST_BURST;
      end
      srb_pkg::ST_BURST: begin
        if (issue && cnt == srb_pkg::LEN_W'(1)) state_next = srb_pkg::ST_IDLE;
      end
      default: state_next = srb_pkg::ST_IDLE;
    endcase
  end

  // control outputs: one read slot a cycle while the staging register can drain
  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    unique case (state)
      srb_pkg::ST_IDLE:  req_ready = 1'b1;
      srb_pkg::ST_BURST: issue = !pend || move;
      default: begin
        req_ready = 1'b0;
        issue     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (accept && req.func == srb_pkg::FUNC_CLEAR) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
      end else begin
        if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // burst registers, captured when a read request is taken; the count steps down on each issue
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start_read) begin
      cnt <= len_sat;
    end else if (issue) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_read) begin
      burst_under <= under;
      burst_level <= srb_pkg::LEVEL_W'(avail);
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= req.sample_in;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_ptr];
  end

  // staging register alongside the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue || (pend && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last  <= (cnt == srb_pkg::LEN_W'(1));
      pend_under <= burst_under;
      pend_level <= burst_level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp.sample_out <= pend_under ? '0 : rd_data;
      rsp.last       <= pend_last;
      rsp.underflow  <= pend_under;
      rsp.level      <= pend_level;
    end
  end

  // a staged sample is never dropped while the output is stalled
  `SRB_ASSERT(a_pend_held, pend && !move |=> pend)
  // an underflow burst leaves the read pointer alone
  `SRB_ASSERT(a_under_no_consume, state == srb_pkg::ST_BURST && burst_under |=> $stable(rd_ptr))
  // a burst always has samples left to issue
  `SRB_ASSERT(a_cnt_live, state == srb_pkg::ST_BURST |-> cnt != '0)
  // the final issue of a burst hands the request side back
  `SRB_ASSERT(a_burst_end, issue && cnt == srb_pkg::LEN_W'(1) |=> req_ready)
  // requests are refused while a burst is issuing
  `SRB_ASSERT_ALWAYS(a_no_req_in_burst, issue |-> !req_ready)

endmodule
`default_nettype wire
